// ===== rtl/lap_pkg.sv =====
// Shared types, widths and constants for the look-at pitch/yaw pipeline.
// No dependencies; every other file of the block imports this package.
package lap_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int TAB_LEN = 24;
   localparam int DIFF_W = 33;
   localparam int COORD_W = 35;
   localparam int ANGLE_W = 16;
   localparam int ZACC_W = 34;
   localparam int DATA_W = 54;
   localparam int GUARD_SH = 16;
   localparam int SQ_IN_W = 64;
   localparam int SQ_OUT_W = 32;
   localparam int REQ_W = 208;
   localparam int RSP_W = 48;

   localparam logic signed [ZACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] PI_Q13 = 16'sd25736;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dz;
      logic signed [DIFF_W-1:0] py;
      logic [ANGLE_W-1:0] roll;
      logic zero;
      logic vert;
   } side_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] roll;
      logic zero;
      logic vert;
   } flag_type;

   // Arctangent of 2^-i, truncated to Q2.30.
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] r;
      case (i)
         0: r = 32'd843314856;
         1: r = 32'd497837829;
         2: r = 32'd263043836;
         3: r = 32'd133525158;
         4: r = 32'd67021686;
         5: r = 32'd33543515;
         6: r = 32'd16775850;
         7: r = 32'd8388437;
         8: r = 32'd4194282;
         9: r = 32'd2097149;
         10: r = 32'd1048575;
         11: r = 32'd524287;
         12: r = 32'd262143;
         13: r = 32'd131071;
         14: r = 32'd65535;
         15: r = 32'd32767;
         16: r = 32'd16383;
         17: r = 32'd8191;
         18: r = 32'd4095;
         19: r = 32'd2047;
         20: r = 32'd1023;
         21: r = 32'd511;
         22: r = 32'd255;
         23: r = 32'd127;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/lap_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband word.
// Depends on lap_pkg.
module lap_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [lap_pkg::SQ_IN_W-1:0]   in_value,
   input  lap_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [lap_pkg::SQ_OUT_W-1:0]  out_root,
   output lap_pkg::side_type             out_side
);
   import lap_pkg::*;

   localparam int REM_W = SQ_OUT_W + 3;

   logic               vld_ff  [0:SQ_OUT_W];
   logic [REM_W-1:0]   rem_ff  [0:SQ_OUT_W];
   logic [SQ_OUT_W-1:0] root_ff [0:SQ_OUT_W];
   logic [SQ_IN_W-1:0] val_ff  [0:SQ_OUT_W];
   side_type           side_ff [0:SQ_OUT_W];

   always_comb begin
      vld_ff[0]  = in_valid;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      val_ff[0]  = in_value;
      side_ff[0] = in_side;
   end

   for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
      logic [REM_W-1:0] rs_in;
      logic [REM_W-1:0] trial_in;
      logic             take_in;

      always_comb begin
         rs_in    = {rem_ff[k][REM_W-3:0], val_ff[k][SQ_IN_W-1 -: 2]};
         trial_in = {1'b0, root_ff[k], 2'b01};
         take_in  = rs_in >= trial_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            rem_ff[k+1]  <= take_in ? rs_in - trial_in : rs_in;
            root_ff[k+1] <= {root_ff[k][SQ_OUT_W-2:0], take_in};
            val_ff[k+1]  <= {val_ff[k][SQ_IN_W-3:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[SQ_OUT_W];
   assign out_root  = root_ff[SQ_OUT_W];
   assign out_side  = side_ff[SQ_OUT_W];

endmodule

// ===== rtl/lap_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.13, one micro-rotation a stage.
// Depends on lap_pkg.
module lap_cordic #(
   parameter int CORDIC_STEPS = lap_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [lap_pkg::COORD_W-1:0]  in_x,
   input  logic signed [lap_pkg::COORD_W-1:0]  in_y,
   output logic                                out_valid,
   output logic signed [lap_pkg::ANGLE_W-1:0]  out_angle
);
   import lap_pkg::*;

   localparam int PAD_W = DATA_W - COORD_W - GUARD_SH;
   localparam int Q_W = ZACC_W - 17;

   logic                     vld_ff [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] x_ff   [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] y_ff   [0:CORDIC_STEPS];
   logic signed [ZACC_W-1:0] z_ff   [0:CORDIC_STEPS];

   logic signed [COORD_W-1:0] fx_in, fy_in;
   logic signed [ZACC_W-1:0]  fz_in;

   // Bring the vector into the right half plane first.
   always_comb begin
      fx_in = in_x;
      fy_in = in_y;
      fz_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            fx_in = in_y;
            fy_in = -in_x;
            fz_in = HALF_PI_Q30;
         end else begin
            fx_in = -in_y;
            fy_in = in_x;
            fz_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0] <= {{PAD_W{fx_in[COORD_W-1]}}, fx_in, {GUARD_SH{1'b0}}};
         y_ff[0] <= {{PAD_W{fy_in[COORD_W-1]}}, fy_in, {GUARD_SH{1'b0}}};
         z_ff[0] <= fz_in;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      localparam logic signed [ZACC_W-1:0] ATAN_K = ZACC_W'(atan_q30(k));
      logic signed [DATA_W-1:0] xs_in, ys_in;

      always_comb begin
         xs_in = x_ff[k] >>> k;
         ys_in = y_ff[k] >>> k;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            if (y_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] + ys_in;
               y_ff[k+1] <= y_ff[k] - xs_in;
               z_ff[k+1] <= z_ff[k] + ATAN_K;
            end else begin
               x_ff[k+1] <= x_ff[k] - ys_in;
               y_ff[k+1] <= y_ff[k] + xs_in;
               z_ff[k+1] <= z_ff[k] - ATAN_K;
            end
         end
      end
   end

   logic signed [ZACC_W-1:0]  zr_in;
   logic signed [Q_W-1:0]     q_in;
   logic signed [ANGLE_W-1:0] ang_in;
   logic                      vout_ff;
   logic signed [ANGLE_W-1:0] ang_ff;

   // Round half up from Q2.30 to Q3.13, then clamp to plus or minus pi.
   always_comb begin
      zr_in = z_ff[CORDIC_STEPS] + ZACC_W'(65536);
      q_in  = zr_in[ZACC_W-1:17];
      if (q_in > Q_W'(PI_Q13)) begin
         ang_in = PI_Q13;
      end else if (q_in < -Q_W'(PI_Q13)) begin
         ang_in = -PI_Q13;
      end else begin
         ang_in = q_in[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= vld_ff[CORDIC_STEPS];
      end
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign out_valid = vout_ff;
   assign out_angle = ang_ff;

endmodule

// ===== rtl/look_at_pitch_yaw.sv =====
// Top level of the look-at block: difference, squares, square root and two CORDICs.
// Depends on lap_pkg, lap_sqrt and lap_cordic.
//
// The block takes a target point, an object position (signed Q16.16) and a roll
// angle, and returns yaw = atan2(dx, -dz) and pitch = atan2(dy, sqrt(dx^2 + dz^2))
// in signed Q3.13 radians, with the roll copied through. When target and position
// coincide the result word carries changed = 0 and all angles zero; a vertical
// direction gives a yaw of pi. The whole path is one pipeline that takes a word in
// every cycle unless the result side stalls. A word passes through the difference,
// the range scaling, the squaring multipliers and the sum, then the square root (one
// root bit per stage), the arctangent pipelines (fold, micro-rotations, rounding) and
// the output register. All stages advance together whenever the output register is
// empty or being read, so a stall on the result side holds every word in place.
module look_at_pitch_yaw #(
   parameter int CORDIC_STEPS = lap_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // target_x, target_y, target_z, position_x, position_y, position_z,
   // current_roll, from the lowest bit up.
   input  logic [lap_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pitch, yaw, roll, from the lowest bit up.
   output logic [lap_pkg::RSP_W-1:0]   rsp_tdata,
   // changed.
   output logic                        rsp_tuser
);
   import lap_pkg::*;

   localparam int FLAG_DLY = CORDIC_STEPS + 2;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage 1: exact 33-bit differences.
   logic                     s1_vld_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [ANGLE_W-1:0]       s1_roll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
      if (en) begin
         s1_dx_ff   <= DIFF_W'($signed(req_tdata[31:0]))
                       - DIFF_W'($signed(req_tdata[127:96]));
         s1_dy_ff   <= DIFF_W'($signed(req_tdata[63:32]))
                       - DIFF_W'($signed(req_tdata[159:128]));
         s1_dz_ff   <= DIFF_W'($signed(req_tdata[95:64]))
                       - DIFF_W'($signed(req_tdata[191:160]));
         s1_roll_ff <= req_tdata[207:192];
      end
   end

   // Stage 2: halve all three components if any one reaches 2^31 in magnitude,
   // so that each square fits 63 bits and their sum fits 64.
   function automatic logic is_big(input logic signed [DIFF_W-1:0] v);
      return (v >= DIFF_W'(64'sd2147483648)) || (v <= -DIFF_W'(64'sd2147483648));
   endfunction

   logic                     s2_vld_ff;
   logic signed [DIFF_W-1:0] s2_px_ff, s2_pz_ff;
   side_type                 s2_side_ff;
   logic                     big_in;

   always_comb begin
      big_in = is_big(s1_dx_ff) || is_big(s1_dy_ff) || is_big(s1_dz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_px_ff        <= big_in ? s1_dx_ff >>> 1 : s1_dx_ff;
         s2_pz_ff        <= big_in ? s1_dz_ff >>> 1 : s1_dz_ff;
         s2_side_ff.py   <= big_in ? s1_dy_ff >>> 1 : s1_dy_ff;
         s2_side_ff.dx   <= s1_dx_ff;
         s2_side_ff.dz   <= s1_dz_ff;
         s2_side_ff.roll <= s1_roll_ff;
         s2_side_ff.zero <= (s1_dx_ff == 0) && (s1_dy_ff == 0) && (s1_dz_ff == 0);
         s2_side_ff.vert <= (s1_dx_ff == 0) && (s1_dz_ff == 0);
      end
   end

   // Stage 3: squares of the magnitudes, 32 by 32 bits each.
   logic [31:0]        mx_in, mz_in;
   logic               s3_vld_ff;
   logic [SQ_IN_W-1:0] s3_sx_ff, s3_sz_ff;
   side_type           s3_side_ff;

   always_comb begin
      mx_in = s2_px_ff < 0 ? 32'(-s2_px_ff) : 32'(s2_px_ff);
      mz_in = s2_pz_ff < 0 ? 32'(-s2_pz_ff) : 32'(s2_pz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (en) begin
         s3_sx_ff   <= SQ_IN_W'(mx_in) * SQ_IN_W'(mx_in);
         s3_sz_ff   <= SQ_IN_W'(mz_in) * SQ_IN_W'(mz_in);
         s3_side_ff <= s2_side_ff;
      end
   end

   // Stage 4: sum of squares.
   logic               s4_vld_ff;
   logic [SQ_IN_W-1:0] s4_sum_ff;
   side_type           s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         s4_sum_ff  <= s3_sx_ff + s3_sz_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // Horizontal distance.
   logic                sq_vld;
   logic [SQ_OUT_W-1:0] sq_root;
   side_type            sq_side;

   lap_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_value  (s4_sum_ff),
      .in_side   (s4_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Both arctangents run side by side over the same number of stages.
   logic                      pitch_vld, yaw_vld;
   logic signed [ANGLE_W-1:0] pitch_ang, yaw_ang;

   lap_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_x      ($signed({{(COORD_W-SQ_OUT_W){1'b0}}, sq_root})),
      .in_y      (COORD_W'(sq_side.py)),
      .out_valid (pitch_vld),
      .out_angle (pitch_ang)
   );

   lap_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_x      (-COORD_W'(sq_side.dz)),
      .in_y      (COORD_W'(sq_side.dx)),
      .out_valid (yaw_vld),
      .out_angle (yaw_ang)
   );

   // The flags and the roll follow the CORDIC stages in a plain delay line.
   flag_type fl_ff [0:FLAG_DLY];

   always_comb begin
      fl_ff[0] = '{roll: sq_side.roll, zero: sq_side.zero, vert: sq_side.vert};
   end

   for (genvar k = 0; k < FLAG_DLY; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   // Output register.
   logic                rsp_vld_ff;
   logic [RSP_W-1:0]    rsp_data_ff;
   logic                rsp_chg_ff;
   logic [RSP_W-1:0]    data_in;
   flag_type            fo;

   always_comb begin
      fo = fl_ff[FLAG_DLY];
      if (fo.zero) begin
         data_in = '0;
      end else begin
         data_in = {fo.roll, (fo.vert ? PI_Q13 : yaw_ang), pitch_ang};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= pitch_vld && yaw_vld;
      end
      if (en) begin
         rsp_data_ff <= data_in;
         rsp_chg_ff  <= !fo.zero;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_chg_ff;

endmodule

// ===== rtl/lap_checker.sv =====
// Port-level checks for the look-at block, bound to its top level.
// Depends on lap_pkg and look_at_pitch_yaw.
module lap_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [lap_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [lap_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser
);
   import lap_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_same_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("unchanged result carries nonzero angles");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= PI_Q13)
                  && ($signed(rsp_tdata[15:0]) >= -PI_Q13)
                  && ($signed(rsp_tdata[31:16]) <= PI_Q13)
                  && ($signed(rsp_tdata[31:16]) >= -PI_Q13))
      else $error("angle outside plus or minus pi");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held off with an empty output");

endmodule

bind look_at_pitch_yaw lap_checker u_lap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the look-at pitch/yaw pipeline.
// Depends on lap_pkg and the look_at_pitch_yaw RTL; predicts every result word itself.
module tb_top;
   import lap_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = CORDIC_STEPS_DEFAULT;
   localparam int DRAIN_CYCLES = STEPS + 60;
   localparam logic signed [63:0] HALF_PI_64 = 64'sd1686629713;
   localparam logic signed [63:0] PI_64 = 64'sd25736;

   // Idling styles for the two sides of the block.
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic        changed;
      logic [15:0] pitch;
      logic [15:0] yaw;
      logic [15:0] roll;
   } angle_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   angle_word_type pending_angles[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;

   look_at_pitch_yaw #(.CORDIC_STEPS(STEPS)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // Arithmetic shift right that rounds towards minus infinity.
   function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v,
                                                    input int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Vectoring arctangent, angle in Q2.30, returned rounded and saturated in Q3.13.
   function automatic logic [15:0] arctan2_q13(input logic signed [63:0] y_in,
                                              input logic signed [63:0] x_in);
      logic signed [63:0] x, y, z, t, xs, ys, q;
      x = x_in;
      y = y_in;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI_64;
         end else begin
            x = -y; y = t; z = -HALF_PI_64;
         end
      end
      x = x * 64'sd65536;
      y = y * 64'sd65536;
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + $signed({32'd0, atan_q30(i)});
         end else begin
            x = x - ys; y = y + xs; z = z - $signed({32'd0, atan_q30(i)});
         end
      end
      q = shr_floor(z + 64'sd65536, 17);
      if (q > PI_64) q = PI_64;
      if (q < -PI_64) q = -PI_64;
      return q[15:0];
   endfunction

   function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic angle_word_type predict_angles(input logic [REQ_W-1:0] d);
      logic signed [63:0] dx, dy, dz, px, py, pz;
      logic [63:0] h;
      angle_word_type r;
      dx = $signed(d[31:0]) - $signed(d[127:96]);
      dy = $signed(d[63:32]) - $signed(d[159:128]);
      dz = $signed(d[95:64]) - $signed(d[191:160]);
      r = '0;
      if (dx == 0 && dy == 0 && dz == 0) return r;
      r.changed = 1'b1;
      // A direction straight up or down has no yaw of its own; the block reports pi.
      if (dx == 0 && dz == 0) r.yaw = PI_Q13;
      else r.yaw = arctan2_q13(dx, -dz);
      px = dx; py = dy; pz = dz;
      if (abs64(px) >= 64'sd2147483648 || abs64(py) >= 64'sd2147483648 ||
          abs64(pz) >= 64'sd2147483648) begin
         px = px >>> 1; py = py >>> 1; pz = pz >>> 1;
      end
      h = int_sqrt(px * px + pz * pz);
      r.pitch = arctan2_q13(py, $signed(h));
      r.roll = d[207:192];
      return r;
   endfunction

   // Sends one word, idling beforehand by the current sender setting. It starts and
   // ends at a falling edge and leaves the valid high, so words can follow with no gap.
   task automatic send_word(input logic [31:0] tx, ty, tz, ox, oy, oz,
                            input logic [15:0] roll);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {roll, oz, oy, ox, tz, ty, tx};
      do @(posedge clock); while (!req_tready);
      pending_angles.push_back(predict_angles({roll, oz, oy, ox, tz, ty, tx}));
      @(negedge clock);
   endtask

   // Receiver side: random stalls, plus an optional long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Result checker: each word against the oldest prediction.
   always @(posedge clock) begin
      angle_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            exp_w = pending_angles.pop_front();
            if (rsp_tuser !== exp_w.changed) begin
               $error("changed: expected %0d actual %0d", exp_w.changed, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== exp_w.pitch) begin
               $error("pitch: expected %0d actual %0d", $signed(exp_w.pitch),
                      $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (rsp_tdata[31:16] !== exp_w.yaw) begin
               $error("yaw: expected %0d actual %0d", $signed(exp_w.yaw),
                      $signed(rsp_tdata[31:16]));
               error_count++;
            end
            if (rsp_tdata[47:32] !== exp_w.roll) begin
               $error("roll: expected %0h actual %0h", exp_w.roll, rsp_tdata[47:32]);
               error_count++;
            end
         end
      end
   end

   task automatic set_idle(input idle_mode_type m);
      send_idle_pct = (m == IDLE_SENDER || m == IDLE_BOTH) ? ((m == IDLE_BOTH) ? 33 : 56) : 0;
      recv_stall_pct = (m == IDLE_RECEIVER || m == IDLE_BOTH) ?
                       ((m == IDLE_BOTH) ? 33 : 56) : 0;
   endtask

   // Drops the valid and waits for every expected word, ending at a falling edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // A coordinate biased towards the extremes and small values.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] mx, mn;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      // Target equal to position, at zero and at the extremes.
      send_word(0, 0, 0, 0, 0, 0, 16'h1234);
      send_word(mx, mn, mx, mx, mn, mx, 16'd25736);
      // Straight up and straight down.
      send_word(5, 65536, 7, 5, 0, 7, 16'hFFFF);
      send_word(0, mn, 0, 0, mx, 0, -16'sd25736);
      // The four axis directions on the horizontal plane.
      send_word(65536, 0, 0, 0, 0, 0, 0);
      send_word(-65536, 0, 0, 0, 0, 0, 0);
      send_word(0, 0, 65536, 0, 0, 0, 0);
      send_word(0, 0, -65536, 0, 0, 0, 0);
      // Largest differences, which take the halved pitch path.
      send_word(mx, mx, mx, mn, mn, mn, 16'h8000);
      send_word(mn, mn, mn, mx, mx, mx, 16'h7FFF);
      send_word(mx, 0, 0, mn, 0, 0, 0);
      send_word(0, mx, 0, 0, mn, 0, 0);
      send_word(0, 0, mn, 0, 0, mx, 0);
      // Near the fold boundary and tiny vectors.
      send_word(1, 1, 0, 0, 0, 0, 1);
      send_word(-1, -1, 1, 0, 0, 0, 2);
      send_word(1, 0, 1, 0, 0, 0, 3);
      send_word(0, -1, 0, 0, 0, 0, 4);
      send_word(mx, mx, mx, 0, 0, 0, 16'h5555);
      send_word(mn, mn, mn, 0, 0, 0, 16'hAAAA);
      wait_drained();
   endtask

   task automatic test_random(input idle_mode_type m, input int n);
      logic [31:0] ox, oy, oz;
      set_idle(m);
      for (int i = 0; i < n; i++) begin
         ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
         if ($urandom_range(15) == 0) send_word(ox, oy, oz, ox, oy, oz, $urandom);
         else if ($urandom_range(15) == 0)
            send_word(ox, rand_coord(), oz, ox, oy, oz, $urandom);
         else send_word(rand_coord(), rand_coord(), rand_coord(), ox, oy, oz, $urandom);
      end
      wait_drained();
   endtask

   // The receiver holds off long enough for the pipeline to fill and push back.
   task automatic test_backpressure();
      set_idle(IDLE_NONE);
      hold_off_cycles = 3 * (STEPS + 40);
      for (int i = 0; i < 2 * (STEPS + 40); i++)
         send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(IDLE_NONE, 150);
      test_random(IDLE_SENDER, 150);
      test_random(IDLE_RECEIVER, 150);
      test_random(IDLE_BOTH, 150);
      test_backpressure();
      set_idle(IDLE_NONE);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_angles.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== look_at_pitch_yaw.f =====
rtl/lap_pkg.sv
rtl/lap_sqrt.sv
rtl/lap_cordic.sv
rtl/look_at_pitch_yaw.sv
rtl/lap_checker.sv
test/tb_top.sv
